// ----- hw/rtl/dgcm_pkg.sv -----
package dgcm_pkg;

  localparam int DENSITY_WIDTH_DEF = 32;

  // log2 result: 6-bit integer part, 16 fraction bits
  localparam int LOG_W     = 22;
  localparam int MAG_W     = 27;
  localparam int EXP_STEPS = 16;
  localparam int DIV_STEPS = 17;

  // stage counts of the channel sections
  localparam int LOG_LAT  = 19;
  localparam int POW_LAT  = 20;
  localparam int TONE_LAT = 23;
  localparam int CH_LAT   = LOG_LAT + POW_LAT + TONE_LAT;

  localparam logic [17:0] F_CAP = 18'd131072;
  localparam logic [17:0] F_ONE = 18'd65536;
  localparam logic [16:0] T_ONE = 17'd65536;

  typedef enum logic [2:0] {
    REG_GAMMA       = 3'd0,
    REG_SMOOTH      = 3'd1,
    REG_RED_EDGES   = 3'd2,
    REG_GREEN_EDGES = 3'd3,
    REG_BLUE_EDGES  = 3'd4,
    REG_RED_MAX     = 3'd5,
    REG_GREEN_MAX   = 3'd6,
    REG_BLUE_MAX    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] gamma;
    logic [31:0] edges;
  } chan_cfg_t;

  typedef logic [EXP_STEPS-1:0][31:0] exp_const_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v_in) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != '0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // c_k = 2^(2^-k) in Q2.30, k = 1..16
  function automatic exp_const_t exp2_consts();
    exp_const_t  c;
    logic [63:0] cur;
    cur = isqrt64(64'h2000_0000_0000_0000);
    for (int k = 0; k < EXP_STEPS; k++) begin
      c[k] = cur[31:0];
      cur  = isqrt64(cur << 30);
    end
    return c;
  endfunction

  localparam exp_const_t EXP2_C = exp2_consts();

endpackage

// ----- hw/rtl/density_gamma_color_mapper_top.sv -----
// Density to colour mapper.
// Input stream (s_axis_*): one pixel per request, three unsigned 16.16
// densities. Output stream (m_axis_*): one 24-bit packed colour per pixel,
// in order.
// Each channel runs (d/max)^gamma as exp2(gamma * (log2 d - log2 max)),
// then either plain scaling to 255 or a smootherstep curve between edges.
// The pipe has three sections: the squaring log2 pipes, the gamma
// multiply and the 16-stage exp2 product chain, then the 17-stage divider
// and smootherstep multipliers. One pixel per clock unless the receiver stalls.
// The whole pipe advances on one enable: it moves when the output register
// is empty or being taken. While the receiver stalls with a result waiting,
// s_axis_tready drops and every stage holds; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipe and loads the register
// defaults: gamma 1.0, plain mode, edges 0..1, maxima 1.0.
// The APB port (64-bit data, register i at byte address 8*i) must only be
// written while the pipe is empty; settings are sampled live by the stages.
module density_gamma_color_mapper_top
  import dgcm_pkg::*;
#(
  parameter int DENSITY_WIDTH = DENSITY_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // red_density, green_density, blue_density (from bit 0 up), zero padded
  input  logic [((3*DENSITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_color
  output logic [23:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  chan_cfg_t                red_cfg, green_cfg, blue_cfg;
  logic [DENSITY_WIDTH-1:0] red_max, green_max, blue_max;
  logic                     smooth;
  logic                     en;
  logic [CH_LAT-1:0]        vld_q;
  logic [7:0]               r_byte, g_byte, b_byte;

  dgcm_regs #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_regs (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .red_cfg_o(red_cfg), .green_cfg_o(green_cfg), .blue_cfg_o(blue_cfg),
    .red_max_o(red_max), .green_max_o(green_max), .blue_max_o(blue_max),
    .smooth_o(smooth)
  );

  // pipe moves unless the output holds an unaccepted result
  assign en            = ~vld_q[CH_LAT-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[CH_LAT-2:0], s_axis_tvalid};
    end
  end

  dgcm_channel #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_red (
    .clk_i, .en_i(en),
    .density_i(s_axis_tdata[DENSITY_WIDTH-1:0]),
    .max_i(red_max), .cfg_i(red_cfg), .smooth_i(smooth), .byte_o(r_byte)
  );

  dgcm_channel #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_green (
    .clk_i, .en_i(en),
    .density_i(s_axis_tdata[2*DENSITY_WIDTH-1:DENSITY_WIDTH]),
    .max_i(green_max), .cfg_i(green_cfg), .smooth_i(smooth), .byte_o(g_byte)
  );

  dgcm_channel #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_blue (
    .clk_i, .en_i(en),
    .density_i(s_axis_tdata[3*DENSITY_WIDTH-1:2*DENSITY_WIDTH]),
    .max_i(blue_max), .cfg_i(blue_cfg), .smooth_i(smooth), .byte_o(b_byte)
  );

  assign m_axis_tvalid = vld_q[CH_LAT-1];
  assign m_axis_tdata  = {r_byte, g_byte, b_byte};

endmodule

// ----- hw/rtl/dgcm_regs.sv -----
module dgcm_regs
  import dgcm_pkg::*;
#(
  parameter int DENSITY_WIDTH = DENSITY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [5:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  output chan_cfg_t                red_cfg_o,
  output chan_cfg_t                green_cfg_o,
  output chan_cfg_t                blue_cfg_o,
  output logic [DENSITY_WIDTH-1:0] red_max_o,
  output logic [DENSITY_WIDTH-1:0] green_max_o,
  output logic [DENSITY_WIDTH-1:0] blue_max_o,
  output logic                     smooth_o
);

  localparam logic [63:0] MAX_RST = 64'h1_0000;

  logic [47:0]              gamma_q;
  logic                     smooth_q;
  logic [31:0]              red_edges_q, green_edges_q, blue_edges_q;
  logic [DENSITY_WIDTH-1:0] red_max_q, green_max_q, blue_max_q;
  logic                     wr_en;
  reg_idx_e                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q       <= 48'h1000_1000_1000;
      smooth_q      <= 1'b0;
      red_edges_q   <= 32'h8000;
      green_edges_q <= 32'h8000;
      blue_edges_q  <= 32'h8000;
      red_max_q     <= MAX_RST[DENSITY_WIDTH-1:0];
      green_max_q   <= MAX_RST[DENSITY_WIDTH-1:0];
      blue_max_q    <= MAX_RST[DENSITY_WIDTH-1:0];
    end else if (wr_en) begin
      unique case (idx)
        REG_GAMMA:       gamma_q       <= pwdata[47:0];
        REG_SMOOTH:      smooth_q      <= pwdata[0];
        REG_RED_EDGES:   red_edges_q   <= pwdata[31:0];
        REG_GREEN_EDGES: green_edges_q <= pwdata[31:0];
        REG_BLUE_EDGES:  blue_edges_q  <= pwdata[31:0];
        REG_RED_MAX:     red_max_q     <= pwdata[DENSITY_WIDTH-1:0];
        REG_GREEN_MAX:   green_max_q   <= pwdata[DENSITY_WIDTH-1:0];
        REG_BLUE_MAX:    blue_max_q    <= pwdata[DENSITY_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAMMA:       prdata = 64'(gamma_q);
      REG_SMOOTH:      prdata = 64'(smooth_q);
      REG_RED_EDGES:   prdata = 64'(red_edges_q);
      REG_GREEN_EDGES: prdata = 64'(green_edges_q);
      REG_BLUE_EDGES:  prdata = 64'(blue_edges_q);
      REG_RED_MAX:     prdata = 64'(red_max_q);
      REG_GREEN_MAX:   prdata = 64'(green_max_q);
      REG_BLUE_MAX:    prdata = 64'(blue_max_q);
    endcase
  end

  assign red_cfg_o   = '{gamma: gamma_q[47:32], edges: red_edges_q};
  assign green_cfg_o = '{gamma: gamma_q[31:16], edges: green_edges_q};
  assign blue_cfg_o  = '{gamma: gamma_q[15:0],  edges: blue_edges_q};
  assign red_max_o   = red_max_q;
  assign green_max_o = green_max_q;
  assign blue_max_o  = blue_max_q;
  assign smooth_o    = smooth_q;

endmodule

// ----- hw/rtl/dgcm_log2.sv -----
module dgcm_log2
  import dgcm_pkg::*;
#(
  parameter int DENSITY_WIDTH = DENSITY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DENSITY_WIDTH-1:0] x_i,
  output logic [LOG_W-1:0]         log_o
);

  logic [DENSITY_WIDTH-1:0] x_q, x1_q;
  logic [5:0]               e_c, e1_q, e2_q;
  logic [63:0]              xn_c;
  logic [31:0]              m2_q;
  logic [31:0]              m_q  [EXP_STEPS];
  logic [15:0]              fr_q [EXP_STEPS];
  logic [5:0]               e_q  [EXP_STEPS];

  // leading one
  always_comb begin
    e_c = '0;
    for (int i = 0; i < DENSITY_WIDTH; i++) begin
      if (x_q[i]) e_c = 6'(i);
    end
  end

  assign xn_c = 64'(x1_q) << (6'd63 - e1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_i;
      x1_q <= x_q;
      e1_q <= e_c;
      m2_q <= xn_c[63:32];
      e2_q <= e1_q;
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_sq
    logic [31:0] mi;
    logic [15:0] fi;
    logic [5:0]  ei;
    logic [63:0] sq;
    logic        hi;
    if (k == 0) begin : g_first
      assign mi = m2_q;
      assign fi = '0;
      assign ei = e2_q;
    end else begin : g_next
      assign mi = m_q[k-1];
      assign fi = fr_q[k-1];
      assign ei = e_q[k-1];
    end
    assign sq = 64'(mi) * 64'(mi);
    assign hi = sq[63];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]  <= hi ? sq[63:32] : sq[62:31];
        fr_q[k] <= {fi[14:0], hi};
        e_q[k]  <= ei;
      end
    end
  end

  assign log_o = {e_q[EXP_STEPS-1], fr_q[EXP_STEPS-1]};

endmodule

// ----- hw/rtl/dgcm_power.sv -----
module dgcm_power
  import dgcm_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [LOG_W-1:0] ld_i,
  input  logic [LOG_W-1:0] lm_i,
  input  logic             zd_i,
  input  logic             zm_i,
  input  logic [15:0]      gamma_i,
  output logic [17:0]      f_o,
  output logic             zm_o
);

  logic             neg1_q, zd1_q, zm1_q;
  logic [LOG_W-1:0] diff1_q;
  logic [38:0]      prod_c;
  logic [MAG_W-1:0] mag2_q;
  logic             neg2_q, zd2_q, zm2_q;
  logic [10:0]      qq_c;
  logic [15:0]      fr3_q;
  logic [4:0]       q3_q;
  logic             cap3_q, zero3_q, zd3_q, zm3_q;

  logic [31:0] acc_q  [EXP_STEPS];
  logic [15:0] fr_q   [EXP_STEPS];
  logic [4:0]  q_q    [EXP_STEPS];
  logic        cap_q  [EXP_STEPS];
  logic        zero_q [EXP_STEPS];
  logic        zd_q   [EXP_STEPS];
  logic        zm_q   [EXP_STEPS];

  logic [5:0]  s_c;
  logic [40:0] sum_c, sh_c;
  logic [17:0] fv_c, f_c;
  logic [17:0] f_q;
  logic        zmf_q;

  assign prod_c = 39'(diff1_q) * 39'(gamma_i) + 39'd2048;
  assign qq_c   = mag2_q[MAG_W-1:16] + 11'(mag2_q[15:0] != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= ld_i < lm_i;
      diff1_q <= (ld_i < lm_i) ? lm_i - ld_i : ld_i - lm_i;
      zd1_q   <= zd_i;
      zm1_q   <= zm_i;
      mag2_q  <= prod_c[38:12];
      neg2_q  <= neg1_q;
      zd2_q   <= zd1_q;
      zm2_q   <= zm1_q;
      zd3_q   <= zd2_q;
      zm3_q   <= zm2_q;
      if (neg2_q) begin
        // ratio below one: integer part -qq, fraction 1 - mag's fraction
        fr3_q   <= 16'(17'h1_0000 - 17'(mag2_q[15:0]));
        q3_q    <= qq_c[4:0];
        cap3_q  <= 1'b0;
        zero3_q <= qq_c > 11'd26;
      end else begin
        fr3_q   <= mag2_q[15:0];
        q3_q    <= '0;
        cap3_q  <= mag2_q[MAG_W-1:16] != '0;
        zero3_q <= 1'b0;
      end
    end
  end

  // 2^fr, one fraction bit per stage, top bit first
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    logic [31:0] ai;
    logic [15:0] fi;
    logic [4:0]  qi;
    logic        ci, zi, zdi, zmi;
    logic [63:0] mul;
    if (k == 0) begin : g_first
      assign ai  = 32'h4000_0000;
      assign fi  = fr3_q;
      assign qi  = q3_q;
      assign ci  = cap3_q;
      assign zi  = zero3_q;
      assign zdi = zd3_q;
      assign zmi = zm3_q;
    end else begin : g_next
      assign ai  = acc_q[k-1];
      assign fi  = fr_q[k-1];
      assign qi  = q_q[k-1];
      assign ci  = cap_q[k-1];
      assign zi  = zero_q[k-1];
      assign zdi = zd_q[k-1];
      assign zmi = zm_q[k-1];
    end
    assign mul = 64'(ai) * 64'(EXP2_C[k]) + 64'h2000_0000;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= fi[EXP_STEPS-1-k] ? mul[61:30] : ai;
        fr_q[k]   <= fi;
        q_q[k]    <= qi;
        cap_q[k]  <= ci;
        zero_q[k] <= zi;
        zd_q[k]   <= zdi;
        zm_q[k]   <= zmi;
      end
    end
  end

  assign s_c   = 6'd14 + 6'(q_q[EXP_STEPS-1]);
  assign sum_c = 41'(acc_q[EXP_STEPS-1]) + (41'd1 << (s_c - 6'd1));
  assign sh_c  = sum_c >> s_c;
  assign fv_c  = (sh_c > 41'(F_CAP)) ? F_CAP : sh_c[17:0];

  always_comb begin
    priority if (zd_q[EXP_STEPS-1]) begin
      f_c = (gamma_i == '0) ? F_ONE : '0;
    end else if (zero_q[EXP_STEPS-1]) begin
      f_c = '0;
    end else if (cap_q[EXP_STEPS-1]) begin
      f_c = F_CAP;
    end else begin
      f_c = fv_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q   <= f_c;
      zmf_q <= zm_q[EXP_STEPS-1];
    end
  end

  assign f_o  = f_q;
  assign zm_o = zmf_q;

endmodule

// ----- hw/rtl/dgcm_tone.sv -----
module dgcm_tone
  import dgcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [17:0] f_i,
  input  logic        zm_i,
  input  logic [31:0] edges_i,
  input  logic        smooth_i,
  output logic [7:0]  byte_o
);

  logic [16:0]        e0_c, e1_c;
  logic signed [19:0] num_c, den_c;
  logic [19:0]        an_c, ad_c;
  logic               force_c;
  logic [16:0]        tf_c;
  logic [26:0]        pl_c;

  logic        force0_q, zm0_q;
  logic [16:0] tf0_q, ad0_q;
  logic [33:0] rem0_q;
  logic [7:0]  pl0_q;

  logic [33:0] rem_q  [DIV_STEPS];
  logic [16:0] quo_q  [DIV_STEPS];
  logic [16:0] ad_q   [DIV_STEPS];
  logic        frc_q  [DIV_STEPS];
  logic [16:0] tf_q   [DIV_STEPS];
  logic [7:0]  pl_q   [DIV_STEPS];
  logic        zmd_q  [DIV_STEPS];

  logic [16:0] t_c, t1_q;
  logic [33:0] t2_q;
  logic [50:0] t3r_q;
  logic [39:0] qraw_c, qrnd_c;
  logic [19:0] q2_q, q3_q;
  logic [51:0] t3s_c;
  logic [32:0] t3_q;
  logic [52:0] prod_q;
  logic [61:0] b_c;
  logic [7:0]  pl1_q, pl2_q, pl3_q, pl4_q;
  logic        zm1_q, zm2_q, zm3_q, zm4_q;
  logic [7:0]  byte_q;

  assign e0_c  = {edges_i[31:16], 1'b0};
  assign e1_c  = {edges_i[15:0], 1'b0};
  assign num_c = $signed(20'(f_i)) - $signed(20'(e0_c));
  assign den_c = $signed(20'(e1_c)) - $signed(20'(e0_c));
  assign an_c  = num_c[19] ? 20'(-num_c) : 20'(num_c);
  assign ad_c  = den_c[19] ? 20'(-den_c) : 20'(den_c);

  always_comb begin
    priority if (den_c == '0) begin
      force_c = 1'b1;
      tf_c    = num_c[19] ? '0 : T_ONE;
    end else if (num_c == '0 || (num_c[19] != den_c[19])) begin
      force_c = 1'b1;
      tf_c    = '0;
    end else if (an_c >= ad_c) begin
      force_c = 1'b1;
      tf_c    = T_ONE;
    end else begin
      force_c = 1'b0;
      tf_c    = '0;
    end
  end

  // plain scaling to a byte
  assign pl_c = (27'(f_i) << 8) - 27'(f_i) + 27'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      force0_q <= force_c;
      tf0_q    <= tf_c;
      ad0_q    <= ad_c[16:0];
      rem0_q   <= (34'(an_c[16:0]) << 16) + 34'(ad_c[16:1]);
      pl0_q    <= (pl_c[26:16] > 11'd255) ? 8'hFF : pl_c[23:16];
      zm0_q    <= zm_i;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [33:0] ri, cmp;
    logic [16:0] qi, adi, tfi;
    logic        fi, zi;
    logic [7:0]  pi;
    logic        take;
    if (i == 0) begin : g_first
      assign ri  = rem0_q;
      assign qi  = '0;
      assign adi = ad0_q;
      assign fi  = force0_q;
      assign tfi = tf0_q;
      assign pi  = pl0_q;
      assign zi  = zm0_q;
    end else begin : g_next
      assign ri  = rem_q[i-1];
      assign qi  = quo_q[i-1];
      assign adi = ad_q[i-1];
      assign fi  = frc_q[i-1];
      assign tfi = tf_q[i-1];
      assign pi  = pl_q[i-1];
      assign zi  = zmd_q[i-1];
    end
    assign cmp  = 34'(adi) << (DIV_STEPS - 1 - i);
    assign take = ri >= cmp;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? ri - cmp : ri;
        quo_q[i] <= qi | (take ? (17'd1 << (DIV_STEPS - 1 - i)) : '0);
        ad_q[i]  <= adi;
        frc_q[i] <= fi;
        tf_q[i]  <= tfi;
        pl_q[i]  <= pi;
        zmd_q[i] <= zi;
      end
    end
  end

  assign t_c    = frc_q[DIV_STEPS-1] ? tf_q[DIV_STEPS-1] : quo_q[DIV_STEPS-1];
  assign qraw_c = 40'(t2_q) * 40'd6 + (40'd10 << 32) - ((40'(t1_q) * 40'd15) << 16);
  assign qrnd_c = qraw_c + 40'd32768;
  assign t3s_c  = 52'(t3r_q) + 52'd32768;
  assign b_c    = (62'(prod_q) << 8) - 62'(prod_q) + (62'd1 << 47);

  // smootherstep: t^2, t^3 and the quadratic, then the product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_c;
      t2_q   <= 34'(t_c) * 34'(t_c);
      pl1_q  <= pl_q[DIV_STEPS-1];
      zm1_q  <= zmd_q[DIV_STEPS-1];
      t3r_q  <= 51'(t2_q) * 51'(t1_q);
      q2_q   <= qrnd_c[35:16];
      pl2_q  <= pl1_q;
      zm2_q  <= zm1_q;
      t3_q   <= t3s_c[48:16];
      q3_q   <= q2_q;
      pl3_q  <= pl2_q;
      zm3_q  <= zm2_q;
      prod_q <= 53'(t3_q) * 53'(q3_q);
      pl4_q  <= pl3_q;
      zm4_q  <= zm3_q;
      priority if (zm4_q) begin
        byte_q <= '0;
      end else if (smooth_i) begin
        byte_q <= (b_c[61:48] > 14'd255) ? 8'hFF : b_c[55:48];
      end else begin
        byte_q <= pl4_q;
      end
    end
  end

  assign byte_o = byte_q;

endmodule

// ----- hw/rtl/dgcm_channel.sv -----
module dgcm_channel
  import dgcm_pkg::*;
#(
  parameter int DENSITY_WIDTH = DENSITY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DENSITY_WIDTH-1:0] density_i,
  input  logic [DENSITY_WIDTH-1:0] max_i,
  input  chan_cfg_t                cfg_i,
  input  logic                     smooth_i,
  output logic [7:0]               byte_o
);

  logic [LOG_W-1:0]   ld, lm;
  logic [LOG_LAT-1:0] zd_q, zm_q;
  logic [17:0]        f;
  logic               zm_f;

  dgcm_log2 #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_log_d (
    .clk_i, .en_i, .x_i(density_i), .log_o(ld)
  );

  dgcm_log2 #(.DENSITY_WIDTH(DENSITY_WIDTH)) u_log_m (
    .clk_i, .en_i, .x_i(max_i), .log_o(lm)
  );

  // zero flags ride alongside the log pipes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zd_q <= {zd_q[LOG_LAT-2:0], density_i == '0};
      zm_q <= {zm_q[LOG_LAT-2:0], max_i == '0};
    end
  end

  dgcm_power u_pow (
    .clk_i, .en_i,
    .ld_i(ld), .lm_i(lm),
    .zd_i(zd_q[LOG_LAT-1]), .zm_i(zm_q[LOG_LAT-1]),
    .gamma_i(cfg_i.gamma),
    .f_o(f), .zm_o(zm_f)
  );

  dgcm_tone u_tone (
    .clk_i, .en_i,
    .f_i(f), .zm_i(zm_f),
    .edges_i(cfg_i.edges), .smooth_i,
    .byte_o
  );

endmodule

// ----- hw/rtl/dgcm_checker.sv -----
module dgcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with output empty");

  // input stalls whenever a result waits
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && pready)
    else $error("output valid during reset");

endmodule

bind density_gamma_color_mapper_top dgcm_checker u_dgcm_checker (.*);

// ----- tb/tb_density_gamma_color_mapper_top.sv -----
`timescale 1ns / 1ps

// Stream test of the density to colour mapper.
// A behavioural predictor per channel (log2 by squaring, gamma scale, exp2
// by constant products, plain or smootherstep tone) builds the expected
// colour for every accepted pixel; the receiver compares results in order.
module tb_density_gamma_color_mapper_top;
  import dgcm_pkg::*;

  localparam int DW    = 32;
  localparam int TDW   = ((3*DW+7)/8)*8;
  localparam int LIMIT = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // red_density, green_density, blue_density (from bit 0 up)
  logic [TDW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // pixel_color
  logic [23:0]     m_axis_tdata;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [5:0]      paddr = '0;
  logic [63:0]     pwdata = '0;
  logic [63:0]     prdata;
  logic            pready;

  density_gamma_color_mapper_top #(.DENSITY_WIDTH(DW)) dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow copy of the register file
  logic [47:0] gamma_sh;
  logic        smooth_sh;
  logic [31:0] edges_sh [3];
  logic [31:0] max_sh [3];

  logic [23:0] colour_q [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle = 0;   // percent of cycles the sender idles
  int          recv_idle = 0;   // percent of cycles the receiver stalls
  bit          hold_off = 1'b0; // long receiver stall in progress

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int          e;
    logic [63:0] m, frac;
    e = 63;
    frac = 0;
    while (x[e] == 1'b0) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= 64'h1_0000_0000) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return (64'(e) << 16) + frac;
  endfunction

  function automatic logic [63:0] exp2_fix(logic [63:0] fr);
    logic [63:0] acc, c;
    acc = 64'd1 << 30;
    c = root_floor(64'd1 << 61);
    for (int k = 1; k <= 16; k++) begin
      if (fr[16-k]) acc = (acc * c + (64'd1 << 29)) >> 30;
      c = root_floor(c << 30);
    end
    return acc;
  endfunction

  function automatic logic [63:0] ratio_pow(logic [63:0] d, logic [63:0] mx,
                                            logic [63:0] g);
    logic [63:0] ld, lm, mag, fr, q, f;
    longint      ip;
    int          s;
    if (d == 0) return (g == 0) ? 64'd65536 : 64'd0;
    ld = log2_fix(d);
    lm = log2_fix(mx);
    if (ld >= lm) begin
      mag = ((ld - lm) * g + 2048) >> 12;
      ip = longint'(mag >> 16);
      fr = mag & 64'hFFFF;
    end else begin
      mag = ((lm - ld) * g + 2048) >> 12;
      q = (mag + 65535) >> 16;
      fr = (q << 16) - mag;
      ip = -longint'(q);
    end
    if (ip >= 1) return 64'd131072;
    if (ip < -26) return 0;
    s = 14 - int'(ip);
    f = (exp2_fix(fr) + (64'd1 << (s - 1))) >> s;
    return (f > 131072) ? 64'd131072 : f;
  endfunction

  function automatic logic [7:0] tone_byte(logic [63:0] f, logic [31:0] edg);
    longint      e0, e1, num, den;
    logic [63:0] t, an, ad, q, t3, b;
    e0 = longint'({edg[31:16], 1'b0});
    e1 = longint'({edg[15:0], 1'b0});
    num = longint'(f) - e0;
    den = e1 - e0;
    if (den == 0) t = (num >= 0) ? 64'd65536 : 64'd0;
    else if (num == 0 || ((num < 0) != (den < 0))) t = 0;
    else begin
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      t = (an >= ad) ? 64'd65536 : ((an << 16) + ad / 2) / ad;
      if (t > 65536) t = 65536;
    end
    q = 6 * t * t + (64'd10 << 32) - ((15 * t) << 16);
    q = (q + 32768) >> 16;
    t3 = (t * t * t + 32768) >> 16;
    b = (255 * (t3 * q) + (64'd1 << 47)) >> 48;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic logic [7:0] channel_val(int ch, logic [31:0] d);
    logic [63:0] f, b, g;
    if (max_sh[ch] == 0) return 0;
    g = 64'((gamma_sh >> (16 * (2 - ch))) & 48'hFFFF);
    f = ratio_pow(64'(d), 64'(max_sh[ch]), g);
    if (smooth_sh) return tone_byte(f, edges_sh[ch]);
    b = (255 * f + 32768) >> 16;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic reg_write(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAMMA:       gamma_sh <= val[47:0];
      REG_SMOOTH:      smooth_sh <= val[0];
      REG_RED_EDGES:   edges_sh[0] <= val[31:0];
      REG_GREEN_EDGES: edges_sh[1] <= val[31:0];
      REG_BLUE_EDGES:  edges_sh[2] <= val[31:0];
      REG_RED_MAX:     max_sh[0] <= val[31:0];
      REG_GREEN_MAX:   max_sh[1] <= val[31:0];
      REG_BLUE_MAX:    max_sh[2] <= val[31:0];
      default: ;
    endcase
  endtask

  // Wait for the pipe to drain before touching registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (CH_LAT + 8) @(posedge clk_i);
  endtask

  // valid stays up after a request so back-to-back pixels need no gap;
  // callers drop it via drain or explicitly when they stop sending
  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    colour_q.push_back({channel_val(0, r), channel_val(1, g), channel_val(2, b)});
  endtask

  function automatic logic [31:0] rand_density();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(32'h1_FFFF);
      2:       return 32'h1_0000 + $urandom_range(255) - 128;
      3:       return $urandom_range(255);
      default: return $urandom_range(32'h3_0000);
    endcase
  endfunction

  task automatic random_pixels(int n);
    repeat (n) send_pixel(rand_density(), rand_density(), rand_density());
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (colour_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected colour %06h", m_axis_tdata);
      end else begin
        if (colour_q[0] !== m_axis_tdata) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("colour mismatch: expected %06h got %06h",
                     colour_q[0], m_axis_tdata);
        end
        void'(colour_q.pop_front());
      end
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_defaults();
    send_pixel(0, 32'hFFFF_FFFF, 32'h1_0000);
    send_pixel(32'h8000, 32'h4000, 1);
    send_pixel(32'h2_0000, 32'h1_8000, 32'hFFFF);
    send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0001);
  endtask

  task automatic test_gamma_plain();
    drain();
    // red 2.2, green zero, blue top value
    reg_write(REG_GAMMA, 64'h2333_0000_FFFF);
    reg_write(REG_RED_MAX, 64'h0040_0000);
    reg_write(REG_GREEN_MAX, 64'd0);
    reg_write(REG_BLUE_MAX, 64'hFFFF_FFFF);
    send_pixel(0, 0, 0);
    send_pixel(32'h0020_0000, 32'h1234, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_pixel(1, 1, 1);
    drain();
    reg_write(REG_GREEN_MAX, 64'd1);
    send_pixel(32'h0030_0000, 0, 32'h7FFF_FFFF);
    random_pixels(10);
  endtask

  task automatic test_smooth_edges();
    drain();
    reg_write(REG_SMOOTH, 64'd1);
    reg_write(REG_GAMMA, 64'h1000_0800_1800);
    reg_write(REG_RED_EDGES, 64'h2000_6000);   // normal order
    reg_write(REG_GREEN_EDGES, 64'h7000_1000); // reversed: falling curve
    reg_write(REG_BLUE_EDGES, 64'h4000_4000);  // equal edges: step
    reg_write(REG_RED_MAX, 64'h1_0000);
    reg_write(REG_GREEN_MAX, 64'h1_0000);
    reg_write(REG_BLUE_MAX, 64'h1_0000);
    send_pixel(0, 0, 0);
    send_pixel(32'h8000, 32'h8000, 32'h8000);
    send_pixel(32'h1_0000, 32'h1_0000, 32'h7FFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0100, 32'h2_0000);
    drain();
    reg_write(REG_RED_EDGES, 64'hFFFF_FFFF);
    reg_write(REG_GREEN_EDGES, 64'd0);
    reg_write(REG_BLUE_EDGES, 64'h0000_FFFF);
    send_pixel(32'h1_FFFF, 32'h4000, 32'h1_0000);
  endtask

  task automatic random_settings();
    reg_write(REG_GAMMA, 64'({16'($urandom_range(16'h4000)), 16'($urandom),
                              16'($urandom_range(16'h3000))}));
    reg_write(REG_SMOOTH, 64'($urandom_range(1)));
    reg_write(REG_RED_EDGES, 64'($urandom));
    reg_write(REG_GREEN_EDGES, 64'({16'($urandom_range(16'h4000)),
                                    16'($urandom_range(16'h8000))}));
    reg_write(REG_BLUE_EDGES, 64'($urandom));
    reg_write(REG_RED_MAX, 64'($urandom_range(32'h4_0000)));
    reg_write(REG_GREEN_MAX, 64'($urandom));
    reg_write(REG_BLUE_MAX, 64'($urandom_range(32'h2_0000, 32'h100)));
  endtask

  task automatic test_random_phases();
    int idle_sets [3][2] = '{'{12, 88}, '{88, 12}, '{0, 0}};
    for (int p = 0; p < 3; p++) begin
      send_idle = idle_sets[p][0];
      recv_idle = idle_sets[p][1];
      for (int s = 0; s < 3; s++) begin
        drain();
        random_settings();
        random_pixels(80);
      end
    end
  endtask

  // Receiver stops for a long stretch while the sender keeps going, then the
  // sender pauses until everything has come out.
  task automatic test_backpressure();
    drain();
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_pixels(100);
    join
    s_axis_tvalid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    random_pixels(20);
  endtask

  initial begin
    gamma_sh = 48'h1000_1000_1000;
    smooth_sh = 1'b0;
    for (int i = 0; i < 3; i++) begin
      edges_sh[i] = 32'h8000;
      max_sh[i] = 32'h1_0000;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_gamma_plain();
    test_smooth_edges();
    test_random_phases();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (CH_LAT + 10) @(posedge clk_i);
    if (mismatches == 0 && colour_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dgcm_pkg.sv
hw/rtl/dgcm_regs.sv
hw/rtl/dgcm_log2.sv
hw/rtl/dgcm_power.sv
hw/rtl/dgcm_tone.sv
hw/rtl/dgcm_channel.sv
hw/rtl/density_gamma_color_mapper_top.sv
hw/rtl/dgcm_checker.sv
tb/tb_density_gamma_color_mapper_top.sv
